// ===== rtl/whc_pkg.sv =====
package whc_pkg;

  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned TableLen        = 24;
  // CORDIC datapath width: 33-bit difference scaled by 256, plus growth
  localparam int unsigned CW = 44;
  localparam int unsigned ZW = 28;

  localparam logic signed [ZW-1:0] AngPi     = 28'sd52707179;
  localparam logic signed [ZW-1:0] AngHalfPi = 28'sd26353589;
  localparam logic signed [ZW-1:0] AngTwoPi  = 28'sd105414358;
  localparam logic signed [15:0]   ErrMax    = 16'sd25736;
  localparam logic signed [23:0]   RateMax   = 24'sd4194304;

  localparam logic [17:0] FwdSpeedRst = 18'd9830;
  localparam logic [11:0] GainRst     = 12'd384;
  localparam logic [16:0] RadiusRst   = 17'd6554;

  typedef enum logic [1:0] {
    RegFwdSpeed = 2'd0,
    RegGain     = 2'd1,
    RegRadius   = 2'd2
  } cfg_reg_e;

  // atan(2^-i) scaled by 2^24
  function automatic logic signed [ZW-1:0] atan_tab(input int unsigned i);
    logic signed [ZW-1:0] t;
    t = '0;
    case (i)
      0: t = 28'sd13176795;  1: t = 28'sd7778716;  2: t = 28'sd4110060;
      3: t = 28'sd2086331;   4: t = 28'sd1047214;  5: t = 28'sd524117;
      6: t = 28'sd262123;    7: t = 28'sd131069;   8: t = 28'sd65536;
      9: t = 28'sd32768;    10: t = 28'sd16384;   11: t = 28'sd8192;
      12: t = 28'sd4096;    13: t = 28'sd2048;    14: t = 28'sd1024;
      15: t = 28'sd512;     16: t = 28'sd256;     17: t = 28'sd128;
      18: t = 28'sd64;      19: t = 28'sd32;      20: t = 28'sd16;
      21: t = 28'sd8;       22: t = 28'sd4;       23: t = 28'sd2;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/waypoint_heading_controller_unit.sv =====
// Waypoint heading controller. One control tick goes in per cycle unless the
// output stalls, and one command comes out per tick, in order. Stages are:
// two front stages (differences and quaternion products), one CORDIC
// pre-rotation stage, one stage per CORDIC iteration for bearing and yaw in
// parallel, then error wrap/round, gain multiply and saturation. Output
// backpressure stalls the whole pipeline in place; s_axis_tready follows
// m_axis_tready or an empty output slot. Config writes are always accepted.
module waypoint_heading_controller_unit #(
  parameter int unsigned CORDIC_STAGES = whc_pkg::CordicStagesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // target_x[31:0], target_y[63:32], current_x[95:64], current_y[127:96],
  // quat_x[143:128], quat_y[159:144], quat_z[175:160], quat_w[191:176]
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // linear_velocity[17:0], angular_rate[41:18], steer_err[57:42], zeros
  output logic [63:0]  m_axis_tdata,
  // reached[0]
  output logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [17:0]  cfg_data_i
);
  import whc_pkg::*;

  localparam int unsigned NS = (CORDIC_STAGES < TableLen) ? CORDIC_STAGES : TableLen;

  logic adv;
  assign adv = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = adv;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  logic [17:0] fwd_q;
  logic [11:0] gain_q;
  logic [16:0] rad_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= FwdSpeedRst; gain_q <= GainRst; rad_q <= RadiusRst;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegFwdSpeed: fwd_q  <= cfg_data_i;
        RegGain:     gain_q <= cfg_data_i[11:0];
        RegRadius:   rad_q  <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // Stage 1: differences, abs, quaternion products
  logic s1_v_q;
  logic signed [32:0] dx_q, dy_q;
  logic [16:0] ax_q, ay_q;
  logic near_q;
  logic signed [31:0] pwz_q, pxy_q, pww_q, pxx_q, pyy_q, pzz_q;
  logic signed [32:0] dx_d, dy_d;
  logic [32:0] axf, ayf;
  assign dx_d = 33'(signed'(s_axis_tdata[31:0])) - 33'(signed'(s_axis_tdata[95:64]));
  assign dy_d = 33'(signed'(s_axis_tdata[63:32])) - 33'(signed'(s_axis_tdata[127:96]));
  assign axf = dx_d[32] ? 33'(-dx_d) : 33'(dx_d);
  assign ayf = dy_d[32] ? 33'(-dy_d) : 33'(dy_d);
  logic signed [15:0] qx, qy, qz, qw;
  assign qx = s_axis_tdata[143:128];
  assign qy = s_axis_tdata[159:144];
  assign qz = s_axis_tdata[175:160];
  assign qw = s_axis_tdata[191:176];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (adv) s1_v_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q <= dx_d; dy_q <= dy_d;
      ax_q <= axf[16:0]; ay_q <= ayf[16:0];
      near_q <= (axf[32:17] == '0) && (ayf[32:17] == '0);
      pwz_q <= qw * qz; pxy_q <= qx * qy; pww_q <= qw * qw;
      pxx_q <= qx * qx; pyy_q <= qy * qy; pzz_q <= qz * qz;
    end
  end

  // Stage 2: squares for reach test, quaternion sums
  logic s2_v_q;
  logic signed [32:0] dx2_q, dy2_q, yy_q, yx_q;
  logic [34:0] dsq_q;
  logic [33:0] rsq_q;
  logic near2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (adv) s2_v_q <= s1_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx2_q <= dx_q; dy2_q <= dy_q;
      dsq_q <= 35'(ax_q) * 35'(ax_q) + 35'(ay_q) * 35'(ay_q);
      rsq_q <= 34'(rad_q) * 34'(rad_q);
      near2_q <= near_q;
      yy_q <= 33'(pwz_q) + 33'(pxy_q);
      yx_q <= 33'(pww_q) + 33'(pxx_q) - 33'(pyy_q) - 33'(pzz_q);
    end
  end
  // yaw y term is 2*(wz+xy): 34 bits
  logic signed [33:0] yy2;
  assign yy2 = {yy_q, 1'b0};

  // Stage 3: CORDIC pre-rotation for both vectors
  logic s3_v_q, rch3_q;
  logic signed [CW-1:0] bx_q, by_q, qx3_q, qy3_q;
  logic signed [ZW-1:0] bz_q, qz3_q;
  logic bzero_q, qzero_q;

  function automatic logic [2*CW+ZW-1:0] prerot(input logic signed [CW-1:0] x,
                                                 input logic signed [CW-1:0] y);
    logic signed [CW-1:0] xo, yo;
    logic signed [ZW-1:0] zo;
    xo = x <<< 8; yo = y <<< 8; zo = '0;
    if (x < 0) begin
      if (y >= 0) begin xo = y <<< 8; yo = -(x <<< 8); zo = AngHalfPi; end
      else begin xo = -(y <<< 8); yo = x <<< 8; zo = -AngHalfPi; end
    end
    return {xo, yo, zo};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (adv) s3_v_q <= s2_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      {bx_q, by_q, bz_q} <= prerot(CW'(dx2_q), CW'(dy2_q));
      {qx3_q, qy3_q, qz3_q} <= prerot(CW'(yx_q), CW'(yy2));
      bzero_q <= (dx2_q == '0) && (dy2_q == '0);
      qzero_q <= (yx_q == '0) && (yy2 == '0);
      rch3_q <= near2_q && (dsq_q < rsq_q);
    end
  end

  // CORDIC iterations, one register stage each
  logic signed [CW-1:0] cbx [NS+1], cby [NS+1], cqx [NS+1], cqy [NS+1];
  logic signed [ZW-1:0] cbz [NS+1], cqz [NS+1];
  logic cv [NS+1], cbzr [NS+1], cqzr [NS+1], crch [NS+1];
  assign cbx[0] = bx_q; assign cby[0] = by_q; assign cbz[0] = bz_q;
  assign cqx[0] = qx3_q; assign cqy[0] = qy3_q; assign cqz[0] = qz3_q;
  assign cv[0] = s3_v_q; assign cbzr[0] = bzero_q; assign cqzr[0] = qzero_q;
  assign crch[0] = rch3_q;

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic v_q, bzr_q, qzr_q, rch_q;
    logic signed [CW-1:0] bxn_q, byn_q, qxn_q, qyn_q;
    logic signed [ZW-1:0] bzn_q, qzn_q;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q <= 1'b0;
      else if (adv) v_q <= cv[i];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        bzr_q <= cbzr[i]; qzr_q <= cqzr[i]; rch_q <= crch[i];
        if (cby[i] > 0) begin
          bxn_q <= cbx[i] + (cby[i] >>> i); byn_q <= cby[i] - (cbx[i] >>> i);
          bzn_q <= cbz[i] + atan_tab(i);
        end else begin
          bxn_q <= cbx[i] - (cby[i] >>> i); byn_q <= cby[i] + (cbx[i] >>> i);
          bzn_q <= cbz[i] - atan_tab(i);
        end
        if (cqy[i] > 0) begin
          qxn_q <= cqx[i] + (cqy[i] >>> i); qyn_q <= cqy[i] - (cqx[i] >>> i);
          qzn_q <= cqz[i] + atan_tab(i);
        end else begin
          qxn_q <= cqx[i] - (cqy[i] >>> i); qyn_q <= cqy[i] + (cqx[i] >>> i);
          qzn_q <= cqz[i] - atan_tab(i);
        end
      end
    end
    assign cv[i+1] = v_q; assign cbzr[i+1] = bzr_q; assign cqzr[i+1] = qzr_q;
    assign crch[i+1] = rch_q;
    assign cbx[i+1] = bxn_q; assign cby[i+1] = byn_q; assign cbz[i+1] = bzn_q;
    assign cqx[i+1] = qxn_q; assign cqy[i+1] = qyn_q; assign cqz[i+1] = qzn_q;
  end

  // Stage E1: error, wrap, round, clamp
  logic signed [ZW:0] e0, ew;
  logic signed [ZW:0] er;
  logic signed [15:0] err_d;
  always_comb begin
    e0 = (cbzr[NS] ? '0 : (ZW+1)'(cbz[NS])) - (cqzr[NS] ? '0 : (ZW+1)'(cqz[NS]));
    // each angle stays within about 1.06 pi, so one 2*pi step wraps the difference
    if (e0 > (ZW+1)'(AngPi)) ew = e0 - (ZW+1)'(AngTwoPi);
    else if (e0 < -(ZW+1)'(AngPi)) ew = e0 + (ZW+1)'(AngTwoPi);
    else ew = e0;
    er = (ew + (ZW+1)'(1024)) >>> 11;
    if (er > (ZW+1)'(ErrMax)) err_d = ErrMax;
    else if (er < -(ZW+1)'(ErrMax)) err_d = -ErrMax;
    else err_d = er[15:0];
  end
  logic e1_v_q, e1_rch_q;
  logic signed [15:0] err_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e1_v_q <= 1'b0;
    else if (adv) e1_v_q <= cv[NS];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin err_q <= err_d; e1_rch_q <= crch[NS]; end
  end

  // Stage E2: gain multiply
  logic e2_v_q, e2_rch_q;
  logic signed [15:0] err2_q;
  logic signed [28:0] prod_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e2_v_q <= 1'b0;
    else if (adv) e2_v_q <= e1_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      err2_q <= err_q; e2_rch_q <= e1_rch_q;
      prod_q <= signed'({1'b0, gain_q}) * err_q;
    end
  end

  // Output stage: round, saturate, zero on reached
  logic signed [28:0] rr;
  logic signed [23:0] rate_d;
  always_comb begin
    rr = (prod_q + 29'sd16) >>> 5;
    if (rr > 29'(RateMax)) rate_d = RateMax;
    else if (rr < -29'(RateMax)) rate_d = -RateMax;
    else rate_d = rr[23:0];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tvalid <= 1'b0;
    else if (adv) m_axis_tvalid <= e2_v_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tdata <= {6'd0, err2_q, e2_rch_q ? 24'd0 : rate_d,
                       e2_rch_q ? 18'd0 : fwd_q};
      m_axis_tuser <= e2_rch_q;
    end
  end

  // A reached command carries zero velocities
  a_reach_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[41:0] == '0)
    else $error("reached with nonzero velocity");
  // Stalled output holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && m_axis_tvalid)
    else $error("output changed under stall");
  // Heading error stays within +-pi
  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[57:42]) <= ErrMax &&
                       $signed(m_axis_tdata[57:42]) >= -ErrMax))
    else $error("heading error out of range");

endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import whc_pkg::*;

  localparam int Stages  = CordicStagesDef;
  localparam int Latency = Stages + 6;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_x;
    logic signed [31:0] current_y;
    logic signed [31:0] current_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_x;
  } tick_t;

  typedef struct packed {
    logic [17:0]        linear_velocity;
    logic signed [23:0] angular_rate;
    logic signed [15:0] steer_err;
    logic               reached;
  } command_t;

  // Steering command prediction and in-order checking
  class steering_scoreboard;
    logic [17:0] fwd_speed;
    logic [11:0] gain;
    logic [16:0] radius;
    command_t    pending_cmds[$];
    int          errors;

    function new();
      fwd_speed = FwdSpeedRst;
      gain      = GainRst;
      radius    = RadiusRst;
      errors    = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [17:0] val);
      case (idx)
        RegFwdSpeed: fwd_speed = val;
        RegGain:     gain = val[11:0];
        RegRadius:   radius = val[16:0];
        default: ;
      endcase
    endfunction

    // angle of (x, y) scaled by 2^24
    function longint vector_angle(longint y, longint x);
      longint ang, t, xs, ys;
      ang = 0;
      if (x == 0 && y == 0) return 0;
      x = x * 256;
      y = y * 256;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; ang = AngHalfPi;
        end else begin
          x = -y; y = t; ang = -AngHalfPi;
        end
      end
      for (int i = 0; i < Stages && i < TableLen; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; ang += atan_tab(i);
        end else begin
          x -= ys; y += xs; ang -= atan_tab(i);
        end
      end
      return ang;
    endfunction

    function void note_tick(tick_t tk);
      longint dx, dy, qx, qy, qz, qw, ax, ay, bearing, yaw, err, rate, pi2;
      command_t c;
      dx = longint'(tk.target_x) - longint'(tk.current_x);
      dy = longint'(tk.target_y) - longint'(tk.current_y);
      qx = tk.quat_x; qy = tk.quat_y; qz = tk.quat_z; qw = tk.quat_w;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      c.reached = 1'b0;
      if (ax < (64'sd1 << 17) && ay < (64'sd1 << 17))
        c.reached = (ax * ax + ay * ay) < longint'(radius) * longint'(radius);
      bearing = vector_angle(dy, dx);
      yaw = vector_angle(2 * (qw * qz + qx * qy), qw * qw + qx * qx - qy * qy - qz * qz);
      err = bearing - yaw;
      pi2 = 2 * longint'(AngPi);
      // wrap into [-pi, pi]
      repeat (2) if (err > AngPi) err -= pi2;
      repeat (2) if (err < -longint'(AngPi)) err += pi2;
      err = (err + 1024) >>> 11;
      if (err > ErrMax) err = ErrMax;
      if (err < -longint'(ErrMax)) err = -longint'(ErrMax);
      rate = (longint'(gain) * err + 16) >>> 5;
      if (rate > RateMax) rate = RateMax;
      if (rate < -longint'(RateMax)) rate = -longint'(RateMax);
      c.linear_velocity = c.reached ? '0 : fwd_speed;
      c.angular_rate    = c.reached ? '0 : rate[23:0];
      c.steer_err       = err[15:0];
      pending_cmds.push_back(c);
    endfunction

    function void check_command(command_t got);
      command_t e;
      if (pending_cmds.size() == 0) begin
        $error("unexpected command %p", got);
        errors++;
        return;
      end
      e = pending_cmds.pop_front();
      if (got.linear_velocity !== e.linear_velocity) begin
        $error("linear_velocity exp %0d got %0d", e.linear_velocity, got.linear_velocity);
        errors++;
      end
      if (got.angular_rate !== e.angular_rate) begin
        $error("angular_rate exp %0d got %0d", e.angular_rate, got.angular_rate);
        errors++;
      end
      if (got.steer_err !== e.steer_err) begin
        $error("steer_err exp %0d got %0d", e.steer_err, got.steer_err);
        errors++;
      end
      if (got.reached !== e.reached) begin
        $error("reached exp %0d got %0d", e.reached, got.reached);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [17:0]  cfg_data_i = '0;

  steering_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 1'b0;

  waypoint_heading_controller_unit DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random stalls plus a long hold-off on request
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      sb.check_command('{m_axis_tdata[17:0], m_axis_tdata[41:18], m_axis_tdata[57:42],
                         m_axis_tuser});
    end
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one transaction; valid stays high into the next call unless idling
  task automatic send_tick(tick_t tk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= tk;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_tick(tk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [17:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_cmds.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_quat();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(32768) - 16384);
      default: return 16'($urandom_range(400) - 200);
    endcase
  endfunction

  function automatic tick_t rand_tick();
    tick_t tk;
    tk.current_x = $urandom;
    tk.current_y = $urandom;
    case ($urandom_range(3))
      0: begin
        tk.target_x = $urandom; tk.target_y = $urandom;
      end
      1: begin
        // near the robot, around the reach radius
        tk.target_x = tk.current_x + 32'($urandom_range(20000) - 10000);
        tk.target_y = tk.current_y + 32'($urandom_range(20000) - 10000);
      end
      default: begin
        tk.target_x = tk.current_x + 32'($urandom_range(2000000) - 1000000);
        tk.target_y = tk.current_y + 32'($urandom_range(2000000) - 1000000);
      end
    endcase
    tk.quat_x = rand_quat(); tk.quat_y = rand_quat();
    tk.quat_z = rand_quat(); tk.quat_w = rand_quat();
    return tk;
  endfunction

  function automatic tick_t mk(int tx, int ty, int cx, int cy,
                               int qx, int qy, int qz, int qw);
    return '{16'(qw), 16'(qz), 16'(qy), 16'(qx), cy, cx, ty, tx};
  endfunction

  initial begin
    #100ms;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero vectors, reach boundary, axis bearings, wrap, extremes
    send_tick(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send_tick(mk(6553, 0, 0, 0, 0, 0, 0, 16384));
    send_tick(mk(6554, 0, 0, 0, 0, 0, 0, 16384));
    send_tick(mk(0, 6554, 0, 0, 0, 0, 0, 16384));
    send_tick(mk(-65536, 0, 0, 0, 0, 0, 0, 16384));
    send_tick(mk(-65536, 1, 0, 0, 0, 0, 0, 16384));
    send_tick(mk(-65536, -1, 0, 0, 0, 0, 0, 16384));
    send_tick(mk(0, -65536, 0, 0, 0, 0, 16384, 0));
    send_tick(mk(-65536, -1, 0, 0, 0, 0, 16384, 0));
    send_tick(mk(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                 16384, -16384, 16384, -16384));
    send_tick(mk(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                 -16384, 16384, -16384, 16384));
    send_tick(mk(3, 1, 0, 0, 0, 0, -11585, 11585));
    send_tick(mk(100, 100, 0, 0, 32767, -32768, 32767, -32768));
    send_tick(mk(131071, 0, 0, 0, 0, 0, 0, -16384));
    send_tick(mk(131072, 0, 0, 0, 0, 0, 0, 1));
    drain();

    // Phases over register settings and idling mixes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(RegFwdSpeed, 18'd0); write_reg(RegGain, 12'd4095);
                 write_reg(RegRadius, 17'd65536); end
        1: begin write_reg(RegFwdSpeed, 18'h3ffff); write_reg(RegGain, 12'd0);
                 write_reg(RegRadius, 17'd0); end
        2: begin write_reg(RegFwdSpeed, 18'd131072); write_reg(RegGain, 12'd1);
                 write_reg(RegRadius, 17'h1ffff); end
        default: begin
          write_reg(RegFwdSpeed, 18'($urandom));
          write_reg(RegGain, 12'($urandom));
          write_reg(RegRadius, 17'($urandom_range(20000)));
        end
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      if (ph == 4) begin
        // long receiver hold-off so the pipeline fills and backs up
        fork
          begin
            hold_off = 1'b1;
            repeat (200) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      repeat (50) send_tick(rand_tick());
      drain();
    end

    if (sb.errors == 0 && sb.pending_cmds.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
